/* sv/rssv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial slit-scan video package
// Beat types, register codes and default sizes shared by the block.
// ----------------------------------------------------------------------------
package rssv_pkg;

    localparam int FRAME_DEPTH_DEF  = 64;
    localparam int IMAGE_WIDTH_DEF  = 320;
    localparam int IMAGE_HEIGHT_DEF = 240;

    localparam int CFG_DATA_W = 10;
    localparam int PIX_W      = 24;

    // age in Q8 is sqrt(d2 * 1024), so d2 is scaled up by 2^10 before the root
    localparam int Q_SCALE_SHIFT = 10;
    localparam int ROOT_W        = 32;
    localparam int ROOT_STEPS    = 16;
    localparam int ROOT_STAGES   = 4;
    localparam int ROOT_PER_STG  = ROOT_STEPS / ROOT_STAGES;

    typedef enum logic [0:0] {
        CFG_POINTER_X = 1'b0,
        CFG_POINTER_Y = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic       frame_start;
        logic [8:0] pix_x;
        logic [7:0] pix_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_beat;

    typedef struct packed {
        logic [8:0] out_x;
        logic [7:0] out_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_beat;

endpackage

/* sv/rssv_frame_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame history store
// One write port and two registered read ports over the ring of past frames.
// ----------------------------------------------------------------------------
module rssv_frame_store #(
    parameter int DEPTH_WORDS = 1024,
    parameter int ADDR_W      = $clog2(DEPTH_WORDS)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [rssv_pkg::PIX_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr0,
    input  logic [ADDR_W-1:0]          i_rd_addr1,
    output logic [rssv_pkg::PIX_W-1:0] o_rd_data0,
    output logic [rssv_pkg::PIX_W-1:0] o_rd_data1
);

    logic [rssv_pkg::PIX_W-1:0] r_mem [DEPTH_WORDS];
    logic [rssv_pkg::PIX_W-1:0] r_rd0;
    logic [rssv_pkg::PIX_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd0 <= r_mem[i_rd_addr0];
            r_rd1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

/* sv/radial_slit_scan_video.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial slit-scan video
// Pixel stream in, time-displaced pixel stream out, one beat per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one pixel per beat (i_in_valid / o_in_stall). Output
//   channel: one pixel per beat (o_out_valid / i_out_stall), same position,
//   colour blended from the two past frames picked by the distance from the
//   pointer. Pointer registers are to be written through i_cfg_* only while
//   idle; the block does not enforce this. Throughput is one pixel per cycle
//   while the output is not stalled. A 12 stage pipeline: input, squares,
//   scale, four root stages of four steps, age clamp, address, frame store
//   read/write, blend products, output register. The store takes one write
//   and two reads per cycle in the same stage, so ordering follows the input.
//   Reset clears the pointers, the frame count and the pipeline valid bits;
//   the frame store is not cleared. Each stage holds while the next one is
//   full and stalled, so a stall at the output fills the empty stages first
//   and then reaches o_in_stall; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module radial_slit_scan_video #(
    parameter int FRAME_DEPTH  = rssv_pkg::FRAME_DEPTH_DEF,
    parameter int IMAGE_WIDTH  = rssv_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = rssv_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  rssv_pkg::t_cfg_index            i_cfg_index,
    input  logic [rssv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rssv_pkg::t_in_beat              i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rssv_pkg::t_out_beat             o_out_beat
);

    localparam int NSTG       = 12;
    localparam int SLOT_W     = $clog2(FRAME_DEPTH);
    localparam int HELD_W     = $clog2(FRAME_DEPTH + 1);
    localparam int FRAME_SIZE = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int POS_W      = $clog2(FRAME_SIZE);
    localparam int WORDS      = FRAME_DEPTH * FRAME_SIZE;
    localparam int ADDR_W     = $clog2(WORDS);
    localparam int RW         = rssv_pkg::ROOT_W;

    typedef struct packed {
        logic [8:0]                 x;
        logic [7:0]                 y;
        logic [rssv_pkg::PIX_W-1:0] rgb;
        logic [SLOT_W-1:0]          slot;
        logic [SLOT_W-1:0]          top;
        logic                       inimg;
        logic [POS_W-1:0]           pos;
    } t_carry;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   rdy;
    logic            acc;

    logic [rssv_pkg::CFG_DATA_W-1:0] r_ptr_x;
    logic [rssv_pkg::CFG_DATA_W-1:0] r_ptr_y;
    logic [SLOT_W-1:0]               r_newest_slot, n_newest_slot;
    logic [HELD_W-1:0]               r_frames_held, n_frames_held;

    t_carry r_c [10];

    logic [19:0]       r1_sqx, r1_sqy;
    logic [RW-1:0]     r_rem [rssv_pkg::ROOT_STAGES+1];
    logic [RW-1:0]     r_res [rssv_pkg::ROOT_STAGES+1];
    logic [RW-1:0]     n_rem [rssv_pkg::ROOT_STAGES];
    logic [RW-1:0]     n_res [rssv_pkg::ROOT_STAGES];
    logic [SLOT_W-1:0] r7_s0, r7_s1;
    logic [7:0]        r7_w, r8_w, r9_w;
    logic              r7_z0, r7_z1, r8_z0, r8_z1, r9_z0, r9_z1;
    logic [ADDR_W-1:0] r8_wa, r8_ra0, r8_ra1;
    logic [rssv_pkg::PIX_W-1:0] rd0, rd1;
    logic [16:0]       r10_p0 [3];
    logic [16:0]       r10_p1 [3];
    logic [8:0]        r10_x;
    logic [7:0]        r10_y;
    logic              r10_inimg;
    rssv_pkg::t_out_beat r11_out;

    // ---------------- handshake ----------------
    always_comb begin
        rdy[NSTG] = !i_out_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign acc        = i_in_valid && rdy[0];
    assign o_in_stall = !rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- configuration and frame ring ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_x <= '0;
            r_ptr_y <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rssv_pkg::CFG_POINTER_X: r_ptr_x <= i_cfg_data;
                rssv_pkg::CFG_POINTER_Y: r_ptr_y <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_newest_slot = r_newest_slot;
        n_frames_held = r_frames_held;
        if (acc && (i_in_beat.frame_start || r_frames_held == '0)) begin
            if (r_frames_held != '0) begin
                n_newest_slot = (r_newest_slot == SLOT_W'(FRAME_DEPTH - 1)) ? '0
                                : r_newest_slot + 1'b1;
            end
            if (r_frames_held < HELD_W'(FRAME_DEPTH)) begin
                n_frames_held = r_frames_held + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest_slot <= '0;
            r_frames_held <= '0;
        end else begin
            r_newest_slot <= n_newest_slot;
            r_frames_held <= n_frames_held;
        end
    end

    // ---------------- stage 0: input ----------------
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_c[0].x     <= i_in_beat.pix_x;
            r_c[0].y     <= i_in_beat.pix_y;
            r_c[0].rgb   <= {i_in_beat.red, i_in_beat.green, i_in_beat.blue};
            r_c[0].slot  <= n_newest_slot;
            r_c[0].top   <= SLOT_W'(n_frames_held - 1'b1);
            r_c[0].inimg <= (32'(i_in_beat.pix_x) < 32'(IMAGE_WIDTH))
                         && (32'(i_in_beat.pix_y) < 32'(IMAGE_HEIGHT));
            r_c[0].pos   <= '0;
        end
    end

    // ---------------- stage 1: squares and position ----------------
    logic signed [10:0] dx, dy;
    logic [9:0]         adx, ady;
    t_carry             n_c1;

    always_comb begin
        dx  = $signed({2'b00, r_c[0].x}) - $signed({1'b0, r_ptr_x});
        dy  = $signed({3'b000, r_c[0].y}) - $signed({1'b0, r_ptr_y});
        adx = dx[10] ? 10'(-dx) : dx[9:0];
        ady = dy[10] ? 10'(-dy) : dy[9:0];
        n_c1     = r_c[0];
        n_c1.pos = POS_W'(r_c[0].y) * POS_W'(IMAGE_WIDTH) + POS_W'(r_c[0].x);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_sqx <= 20'(adx) * 20'(adx);
            r1_sqy <= 20'(ady) * 20'(ady);
            r_c[1] <= n_c1;
        end
    end

    // ---------------- stage 2: scale ----------------
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_rem[0] <= RW'(21'(r1_sqx) + 21'(r1_sqy)) << rssv_pkg::Q_SCALE_SHIFT;
            r_res[0] <= '0;
            r_c[2]   <= r_c[1];
        end
    end

    // ---------------- stages 3 to 6: square root ----------------
    for (genvar g = 0; g < rssv_pkg::ROOT_STAGES; g++) begin : g_root
        always_comb begin
            logic [RW-1:0] v_rem;
            logic [RW-1:0] v_res;
            logic [RW-1:0] v_bit;
            v_rem = r_rem[g];
            v_res = r_res[g];
            for (int k = 0; k < rssv_pkg::ROOT_PER_STG; k++) begin
                v_bit = RW'(1) << (RW - 2 - 2 * (g * rssv_pkg::ROOT_PER_STG + k));
                if (v_rem >= v_res + v_bit) begin
                    v_rem = v_rem - (v_res + v_bit);
                    v_res = (v_res >> 1) + v_bit;
                end else begin
                    v_res = v_res >> 1;
                end
            end
            n_rem[g] = v_rem;
            n_res[g] = v_res;
        end

        always_ff @(posedge i_clk) begin
            if (rdy[3+g]) begin
                r_rem[g+1] <= n_rem[g];
                r_res[g+1] <= n_res[g];
                r_c[3+g]   <= r_c[2+g];
            end
        end
    end

    // ---------------- stage 7: age clamp and ring slots ----------------
    logic [7:0]        a0;
    logic [8:0]        a1;
    logic [SLOT_W-1:0] a0c, a1c;
    logic [SLOT_W:0]   s0_t, s1_t;

    always_comb begin
        a0   = r_res[rssv_pkg::ROOT_STAGES][15:8];
        a1   = {1'b0, a0} + 9'd1;
        a0c  = (9'(a0) > 9'(r_c[6].top)) ? r_c[6].top : SLOT_W'(a0);
        a1c  = (a1 > 9'(r_c[6].top)) ? r_c[6].top : SLOT_W'(a1);
        s0_t = {1'b0, r_c[6].slot} - {1'b0, a0c}
             + ((r_c[6].slot < a0c) ? (SLOT_W+1)'(FRAME_DEPTH) : '0);
        s1_t = {1'b0, r_c[6].slot} - {1'b0, a1c}
             + ((r_c[6].slot < a1c) ? (SLOT_W+1)'(FRAME_DEPTH) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r7_s0  <= s0_t[SLOT_W-1:0];
            r7_s1  <= s1_t[SLOT_W-1:0];
            r7_w   <= r_res[rssv_pkg::ROOT_STAGES][7:0];
            r7_z0  <= (a0c == '0);
            r7_z1  <= (a1c == '0);
            r_c[7] <= r_c[6];
        end
    end

    // ---------------- stage 8: store addresses ----------------
    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r8_wa  <= ADDR_W'(r_c[7].slot) * ADDR_W'(FRAME_SIZE) + ADDR_W'(r_c[7].pos);
            r8_ra0 <= ADDR_W'(r7_s0) * ADDR_W'(FRAME_SIZE) + ADDR_W'(r_c[7].pos);
            r8_ra1 <= ADDR_W'(r7_s1) * ADDR_W'(FRAME_SIZE) + ADDR_W'(r_c[7].pos);
            r8_w   <= r7_w;
            r8_z0  <= r7_z0;
            r8_z1  <= r7_z1;
            r_c[8] <= r_c[7];
        end
    end

    // ---------------- stage 9: frame store ----------------
    rssv_frame_store #(
        .DEPTH_WORDS (WORDS),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (rdy[9] && r_vld[8] && r_c[8].inimg),
        .i_wr_addr  (r8_wa),
        .i_wr_data  (r_c[8].rgb),
        .i_rd_en    (rdy[9]),
        .i_rd_addr0 (r8_ra0),
        .i_rd_addr1 (r8_ra1),
        .o_rd_data0 (rd0),
        .o_rd_data1 (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[9]) begin
            r9_w   <= r8_w;
            r9_z0  <= r8_z0;
            r9_z1  <= r8_z1;
            r_c[9] <= r_c[8];
        end
    end

    // ---------------- stage 10: blend products ----------------
    logic [rssv_pkg::PIX_W-1:0] c0, c1;
    logic [8:0]                 wc;

    always_comb begin
        // age 0 is the pixel written in this same beat
        c0 = r9_z0 ? r_c[9].rgb : rd0;
        c1 = r9_z1 ? r_c[9].rgb : rd1;
        wc = 9'd256 - {1'b0, r9_w};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[10]) begin
            for (int ch = 0; ch < 3; ch++) begin
                r10_p0[ch] <= 17'(c0[ch*8 +: 8]) * 17'(wc);
                r10_p1[ch] <= 17'(c1[ch*8 +: 8]) * 17'(r9_w);
            end
            r10_x     <= r_c[9].x;
            r10_y     <= r_c[9].y;
            r10_inimg <= r_c[9].inimg;
        end
    end

    // ---------------- stage 11: output ----------------
    logic [16:0] sum [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = r10_p0[ch] + r10_p1[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[11]) begin
            r11_out.out_x     <= r10_x;
            r11_out.out_y     <= r10_y;
            r11_out.out_red   <= r10_inimg ? sum[2][15:8] : 8'd0;
            r11_out.out_green <= r10_inimg ? sum[1][15:8] : 8'd0;
            r11_out.out_blue  <= r10_inimg ? sum[0][15:8] : 8'd0;
        end
    end

    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_beat  = r11_out;

endmodule

/* sv/rssv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial slit-scan video checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rssv_checker #(
    parameter int IMAGE_WIDTH  = rssv_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = rssv_pkg::IMAGE_HEIGHT_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_wr_en,
    input rssv_pkg::t_cfg_index            i_cfg_index,
    input logic [rssv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input rssv_pkg::t_in_beat              i_in_beat,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input rssv_pkg::t_out_beat             o_out_beat
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled output beat dropped");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output is empty");

    a_off_image_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (32'(o_out_beat.out_x) >= 32'(IMAGE_WIDTH)
                     || 32'(o_out_beat.out_y) >= 32'(IMAGE_HEIGHT))
        |-> (o_out_beat.out_red == 8'd0 && o_out_beat.out_green == 8'd0
             && o_out_beat.out_blue == 8'd0))
        else $error("off-image beat carries colour");

endmodule

bind radial_slit_scan_video rssv_checker #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_rssv_checker (.*);
